FILE: design/nfa_pkg.sv
// shared constants, command codes and engine handshake types
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_SYMBOLS = 16;
	localparam int ROWS        = NUM_STATES * NUM_SYMBOLS;
	localparam int STATE_W     = NUM_STATES;
	localparam int ST_IDX_W    = $clog2(NUM_STATES);
	localparam int ROW_W       = $clog2(ROWS);

	localparam int CMD_W     = 2;
	localparam int SYM_W     = 4;
	localparam int FROM_W    = 4;
	localparam int MASK_W    = 16;
	localparam int INIT_W    = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SYM   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 1'd1;

	typedef struct packed {
		logic               start;
		logic               wr;
		logic [SYM_W-1:0]   sym;
		logic [FROM_W-1:0]  from;
		logic [MASK_W-1:0]  mask;
		logic [STATE_W-1:0] set;
	} eng_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [STATE_W-1:0] next_set;
	} eng_rsp_t;

endpackage
`default_nettype wire

FILE: design/nfa_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface nfa_cmd_if;
	import nfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [SYM_W-1:0]  symbol;
	logic [FROM_W-1:0] from_state;
	logic [MASK_W-1:0] next_mask;

	modport source(output valid, cmd, symbol, from_state, next_mask, input ready);
	modport sink(input valid, cmd, symbol, from_state, next_mask, output ready);
endinterface

interface nfa_res_if;
	logic valid;
	logic ready;
	logic accepted;
	logic alive;

	modport source(output valid, accepted, alive, input ready);
	modport sink(input valid, accepted, alive, output ready);
endinterface
`default_nettype wire

FILE: design/nfa_word_acceptor_core.sv
// top level: request decode, configuration registers and result register
`timescale 1ns / 1ps
`default_nettype none
// NFA word acceptor. Software loads transition rows (cmd 0), feeds symbols (cmd 1)
// and closes each word (cmd 2), which returns accepted and alive on the result
// channel. Each symbol runs a scan: the single-port transition
// memory is read once per state, whether active or not, and the request channel
// is held off until the new active set is in place. The table comes out of reset
// empty through one valid bit per row, so no clearing pass is needed. Write the
// start state and final mask registers only while no symbol is being processed.
module nfa_word_acceptor_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [nfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nfa_pkg::CFG_W-1:0]     cfg_wdata,
	nfa_cmd_if.sink                           req_ch,
	nfa_res_if.source                         res_ch
);
	import nfa_pkg::*;

	logic [INIT_W-1:0]  init_q;
	logic [STATE_W-1:0] final_q;
	logic [STATE_W-1:0] active_q;
	logic               word_start_q;
	logic               res_valid_q;
	logic               accepted_q;
	logic               alive_q;

	logic [STATE_W-1:0] start_set;
	logic [STATE_W-1:0] cur_set;
	logic               req_acc;
	eng_req_t           eng_req;
	eng_rsp_t           eng_rsp;

	assign start_set = (32'(init_q) < 32'(NUM_STATES)) ?
		(STATE_W'(1) << init_q) : '0;
	assign cur_set   = word_start_q ? start_set : active_q;

	// an end of word also needs the result slot to be free
	assign req_ch.ready = !eng_rsp.busy &&
		(req_ch.cmd != CMD_END || !res_valid_q || res_ch.ready);
	assign req_acc = req_ch.valid && req_ch.ready;

	assign eng_req.start = req_acc && req_ch.cmd == CMD_SYM;
	assign eng_req.wr    = req_acc && req_ch.cmd == CMD_WRITE;
	assign eng_req.sym   = req_ch.symbol;
	assign eng_req.from  = req_ch.from_state;
	assign eng_req.mask  = req_ch.next_mask;
	assign eng_req.set   = cur_set;

	nfa_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (eng_req),
		.rsp   (eng_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			final_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT:  init_q  <= INIT_W'(cfg_wdata);
				CFG_FINAL: final_q <= STATE_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_start_q <= 1'b1;
			active_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (eng_rsp.done) begin
				active_q <= eng_rsp.next_set;
			end
			if (req_acc && req_ch.cmd == CMD_SYM) begin
				word_start_q <= 1'b0;
			end else if (req_acc && req_ch.cmd == CMD_END) begin
				word_start_q <= 1'b1;
			end
			if (req_acc && req_ch.cmd == CMD_END) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && req_ch.cmd == CMD_END) begin
			accepted_q <= |(cur_set & final_q);
			alive_q    <= |cur_set;
		end
	end

	assign res_ch.valid    = res_valid_q;
	assign res_ch.accepted = accepted_q;
	assign res_ch.alive    = alive_q;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_ch.cmd == CMD_END |=> res_valid_q)
		else $error("end of word did not load a result");

	a_accept_implies_alive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (alive_q || !accepted_q))
		else $error("accepted reported with an empty state set");

	a_scan_leaves_word_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(eng_rsp.busy) |-> !word_start_q)
		else $error("symbol scan running while still at word start");

	a_done_frees_engine: assert property (@(posedge clk) disable iff (!arst_n)
		eng_rsp.done |=> !eng_rsp.busy)
		else $error("engine still busy after finishing a scan");
endmodule
`default_nettype wire

FILE: design/nfa_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module nfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: design/nfa_engine.sv
// transition table and the row scan that builds the next state set
`timescale 1ns / 1ps
`default_nettype none
module nfa_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nfa_pkg::eng_req_t req,
	output nfa_pkg::eng_rsp_t      rsp
);
	import nfa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [ST_IDX_W-1:0] LAST = ST_IDX_W'(NUM_STATES - 1);

	function automatic logic [ROW_W-1:0] row_addr(input logic [ST_IDX_W-1:0] st,
			input logic [SYM_W-1:0] sym);
		row_addr = ROW_W'(ROW_W'(st) * ROW_W'(NUM_SYMBOLS) + ROW_W'(sym));
	endfunction

	logic [1:0]          state_q;
	logic [ST_IDX_W-1:0] cnt_q;
	logic [STATE_W-1:0]  set_q;
	logic [SYM_W-1:0]    sym_q;
	logic                sym_ok_q;
	logic [STATE_W-1:0]  acc_q;
	logic                hit_s1;
	logic [ROWS-1:0]     valid_q;

	logic [ROW_W-1:0]   scan_addr;
	logic [ROW_W-1:0]   wr_addr;
	logic [ROW_W-1:0]   ram_addr;
	logic               wr_ok;
	logic               ram_we;
	logic [STATE_W-1:0] rdata;
	logic [STATE_W-1:0] hit_row;

	assign scan_addr = row_addr(cnt_q, sym_q);
	assign wr_addr   = row_addr(ST_IDX_W'(req.from), req.sym);
	assign wr_ok     = (32'(req.from) < 32'(NUM_STATES)) && (32'(req.sym) < 32'(NUM_SYMBOLS));
	assign ram_we    = req.wr && wr_ok;
	assign ram_addr  = (state_q == ST_IDLE) ? wr_addr : scan_addr;
	assign hit_row   = hit_s1 ? rdata : '0;

	nfa_ram #(
		.WIDTH(STATE_W),
		.DEPTH(ROWS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(STATE_W'(req.mask)),
		.rdata(rdata)
	);

	// rows never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hit_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					hit_s1 <= 1'b0;
					if (req.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read issued now, row arrives next cycle
					hit_s1 <= set_q[cnt_q] & valid_q[scan_addr] & sym_ok_q;
					if (cnt_q == LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					hit_s1  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					hit_s1  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			set_q    <= req.set;
			sym_q    <= req.sym;
			sym_ok_q <= 32'(req.sym) < 32'(NUM_SYMBOLS);
			cnt_q    <= '0;
			acc_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			acc_q <= acc_q | hit_row;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign rsp.busy     = state_q != ST_IDLE;
	assign rsp.done     = state_q == ST_DRAIN;
	assign rsp.next_set = acc_q | hit_row;
endmodule
`default_nettype wire

FILE: bench/nfa_verdict_checker.sv
// word verdict checker: tracks the automaton from observed requests and checks each result
`timescale 1ns / 1ps
module nfa_verdict_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfa_pkg::CFG_W-1:0]     cfg_wdata,
	nfa_cmd_if                            req_mon,
	nfa_res_if                            res_mon,
	output int                            fail_count,
	output int                            outstanding,
	output int                            verdicts_checked,
	output int                            accepts_seen
);
	import nfa_pkg::*;

	typedef struct packed {
		logic accepted;
		logic alive;
	} verdict_t;

	logic [STATE_W-1:0] next_rows [NUM_STATES][NUM_SYMBOLS];
	logic [STATE_W-1:0] active_states;
	logic               word_start;
	logic [INIT_W-1:0]  init_state;
	logic [STATE_W-1:0] final_states;
	verdict_t           verdict_q [$];

	function automatic logic [STATE_W-1:0] start_states();
		if (init_state >= NUM_STATES)
			return '0;
		return STATE_W'(1) << init_state;
	endfunction

	function automatic logic [STATE_W-1:0] current_states();
		return word_start ? start_states() : active_states;
	endfunction

	// union of the rows of every active state for this symbol
	function automatic logic [STATE_W-1:0] follow_symbol(input logic [STATE_W-1:0] cur,
		input logic [SYM_W-1:0] sym);
		logic [STATE_W-1:0] reach;
		reach = '0;
		if (sym < NUM_SYMBOLS)
			for (int s = 0; s < NUM_STATES; s++)
				if (cur[s])
					reach |= next_rows[s][sym];
		return reach;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 20)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int               pushed;
		int               popped;
		verdict_t         want;
		logic [STATE_W-1:0] cur;
		if (!arst_n) begin
			for (int s = 0; s < NUM_STATES; s++)
				for (int y = 0; y < NUM_SYMBOLS; y++)
					next_rows[s][y] = '0;
			init_state       = '0;
			final_states     = '0;
			word_start       = 1'b1;
			active_states    = start_states();
			verdict_q.delete();
			outstanding      <= 0;
			fail_count       = 0;
			verdicts_checked = 0;
			accepts_seen     = 0;
		end else begin
			pushed = 0;
			popped = 0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INIT: begin
						init_state = cfg_wdata[INIT_W-1:0];
						if (word_start)
							active_states = start_states();
					end
					CFG_FINAL: final_states = cfg_wdata[STATE_W-1:0];
					default: ;
				endcase
			end
			if (req_mon.valid && req_mon.ready) begin
				case (req_mon.cmd)
					CMD_WRITE: begin
						if (req_mon.from_state < NUM_STATES && req_mon.symbol < NUM_SYMBOLS)
							next_rows[req_mon.from_state][req_mon.symbol] =
								req_mon.next_mask[STATE_W-1:0];
					end
					CMD_SYM: begin
						active_states = follow_symbol(current_states(), req_mon.symbol);
						word_start = 1'b0;
					end
					CMD_END: begin
						cur = current_states();
						want.accepted = |(cur & final_states);
						want.alive    = |cur;
						verdict_q = {verdict_q, want};
						pushed = 1;
						word_start = 1'b1;
						active_states = start_states();
					end
					default: ;
				endcase
			end
			if (res_mon.valid && res_mon.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result with no end of word pending");
				end else begin
					want = verdict_q.pop_front();
					popped = 1;
					verdicts_checked++;
					if (res_mon.accepted === 1'b1)
						accepts_seen++;
					if (res_mon.accepted !== want.accepted)
						report_mismatch($sformatf("accepted %b, expected %b",
							res_mon.accepted, want.accepted));
					if (res_mon.alive !== want.alive)
						report_mismatch($sformatf("alive %b, expected %b",
							res_mon.alive, want.alive));
				end
			end
			outstanding <= outstanding + pushed - popped;
		end
	end

endmodule

FILE: bench/tb_top.sv
// testbench top: reset, register settings, request stimulus, result backpressure, verdict
`timescale 1ns / 1ps
module tb_top;
	import nfa_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 130;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 steady;
	int                   reqs_sent;
	int                   settings_done;
	int                   idle_cycles;
	int                   fail_count;
	int                   outstanding;
	int                   verdicts_checked;
	int                   accepts_seen;

	nfa_cmd_if req_ch();
	nfa_res_if res_ch();

	nfa_word_acceptor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_ch    (req_ch),
		.res_ch    (res_ch)
	);

	nfa_verdict_checker u_verdicts (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_mon          (req_ch),
		.res_mon          (res_ch),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.verdicts_checked (verdicts_checked),
		.accepts_seen     (accepts_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ch.ready <= steady || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// sparse rows mostly, so active sets neither die out nor fill up at once
	function automatic logic [MASK_W-1:0] row_mask();
		logic [MASK_W-1:0] m;
		case ($urandom_range(9))
			0: m = '0;
			1: m = '1;
			2, 3: m = MASK_W'(1) << $urandom_range(MASK_W - 1);
			default: m = MASK_W'($urandom & $urandom & $urandom) |
				(MASK_W'(1) << $urandom_range(MASK_W - 1));
		endcase
		return m;
	endfunction

	task automatic send_req(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] sym,
		input logic [FROM_W-1:0] from, input logic [MASK_W-1:0] mask);
		while (!steady && $urandom_range(99) < 27) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.symbol     <= sym;
		req_ch.from_state <= from;
		req_ch.next_mask  <= mask;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		reqs_sent++;
	endtask

	// idle the request side and wait out every pending verdict and any symbol in flight
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [INIT_W-1:0] init_st, input logic [MASK_W-1:0] fin);
		logic [CFG_W-1:0] word;
		word = CFG_W'($urandom);
		word[INIT_W-1:0] = init_st;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INIT;
		cfg_wdata <= word;
		@(posedge clk);
		cfg_index <= CFG_FINAL;
		cfg_wdata <= fin;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	task automatic run_phase(input int n_rows, input int alpha);
		int sent;
		int len;
		int pick;
		sent = 0;
		repeat (n_rows) begin
			send_req(CMD_WRITE, SYM_W'($urandom_range(alpha - 1)), FROM_W'($urandom),
				row_mask());
			sent++;
		end
		while (sent < PHASE_ITEMS) begin
			len = $urandom_range(6);
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(99);
				if (pick < 6)
					send_req(CMD_UNUSED, SYM_W'($urandom), FROM_W'($urandom),
						MASK_W'($urandom));
				else if (pick < 10)
					send_req(CMD_WRITE, SYM_W'($urandom_range(alpha - 1)),
						FROM_W'($urandom), row_mask());
				else
					send_req(CMD_SYM, SYM_W'($urandom_range(alpha - 1)), FROM_W'($urandom),
						MASK_W'($urandom));
				sent++;
			end
			send_req(CMD_END, SYM_W'($urandom), FROM_W'($urandom), MASK_W'($urandom));
			sent++;
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_INIT;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_WRITE;
		req_ch.symbol     = '0;
		req_ch.from_state = '0;
		req_ch.next_mask  = '0;
		steady            = 1'b0;
		reqs_sent         = 0;
		settings_done     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: start in state 0, nothing final, empty table
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_UNUSED, 4'hF, 4'hF, 16'hFFFF);
		send_req(CMD_SYM, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_SYM, 4'hF, 4'hF, 16'hFFFF);
		send_req(CMD_END, 4'hF, 4'hF, 16'hFFFF);
		send_req(CMD_WRITE, 4'h0, 4'h0, 16'hFFFF);
		send_req(CMD_WRITE, 4'hF, 4'hF, 16'h8000);
		send_req(CMD_WRITE, 4'h0, 4'hF, 16'h0000);
		send_req(CMD_SYM, 4'h0, 4'h5, 16'h1234);
		send_req(CMD_SYM, 4'hF, 4'hA, 16'hABCD);
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);
		settle();
		set_config(4'hF, 16'h8000);
		send_req(CMD_SYM, 4'hF, 4'h0, 16'h0000);
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_SYM, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_UNUSED, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);
		// empty word from an accepting start state
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);
		send_req(CMD_WRITE, 4'hF, 4'hF, 16'h0000);
		send_req(CMD_SYM, 4'hF, 4'h0, 16'h0000);
		send_req(CMD_END, 4'h0, 4'h0, 16'h0000);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: set_config(4'h0, MASK_W'($urandom));
				1: set_config(4'hF, 16'hFFFF);
				3: set_config(INIT_W'($urandom), 16'h0000);
				5: set_config(4'h0, 16'h8001);
				7: set_config(4'hF, MASK_W'($urandom));
				default: set_config(INIT_W'($urandom), MASK_W'($urandom));
			endcase
			// one phase runs with no idling on either side
			steady = (p == 2);
			run_phase((p == 0) ? 40 : 24, (p % 2 == 0) ? NUM_SYMBOLS : 4);
		end
		steady = 1'b0;
		settle();

		$display("sent %0d requests across %0d register settings", reqs_sent, settings_done);
		$display("checked %0d word verdicts, %0d of them accepting", verdicts_checked,
			accepts_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
